/* hw/rtl/cce_pkg.sv */
// Shared types and constants for the character canvas engine.
// Holds the request codes, key codes, transfer payload structs and FSM states.
// Depends on nothing; every canvas engine file imports it.
package cce_pkg;

  localparam int DEF_ROWS = 22;
  localparam int DEF_COLS = 80;

  // Width of the signed source row/column calculation during a shift.
  localparam int SRC_W = 10;

  localparam logic [2:0] REQ_KEY     = 3'd0;
  localparam logic [2:0] REQ_REPLACE = 3'd1;
  localparam logic [2:0] REQ_SHIFT   = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_START   = 3'd4;

  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_LEFT      = 8'd75;
  localparam logic [7:0] KEY_UP        = 8'd72;
  localparam logic [7:0] KEY_RIGHT     = 8'd77;
  localparam logic [7:0] KEY_DOWN      = 8'd80;
  localparam logic [7:0] KEY_ARROW_PFX = 8'd224;
  localparam logic [7:0] KEY_NULL_PFX  = 8'd0;
  localparam logic [7:0] PRINT_LO      = 8'd32;
  localparam logic [7:0] PRINT_HI      = 8'd126;
  localparam logic [7:0] SPACE_CHAR    = 8'd32;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_ARROW,
    PFX_DISCARD
  } prefix_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [7:0]        key_code;
    logic [7:0]        old_char;
    logic [7:0]        new_char;
    logic signed [7:0] row_shift;
    logic signed [7:0] col_shift;
    logic [4:0]        read_row;
    logic [6:0]        read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       editing;
  } out_item_t;

endpackage

/* hw/rtl/character_canvas_engine_top.sv */
// Character canvas engine: canvas memory, edit cursor and cell sweep sequencer.
// Depends on cce_pkg for payload structs, codes and state encoding.
//
// Usage:
//   Requests arrive on the in_* channel (valid/stall) as one in_item_t per
//   transfer; each request gives exactly one out_item_t on the out_* channel.
//   Request types are key byte, replace all, shift, read cell and start edit.
//   The block works on one request at a time and holds in_stall_o high from
//   the accepting edge until it is back in idle.
//   Key, start and unused codes pass through decode and done; a read adds a
//   read state, and replace and shift add a sweep and a drain state. Replace
//   and shift run one cell per cycle through the single read port and single
//   write port of the canvas memory.
//   After reset all ROWS*COLS cells (1760 at the default size) are swept to
//   spaces, one cell per cycle, with in_stall_o high.
//   Cursor, prefix and session state reset to home, none and inactive.
//   A finished result sits in an output register; the next request is taken
//   while it waits, and a request only blocks at its end if the receiver is
//   still stalling the previous result.
module character_canvas_engine_top #(
  parameter int ROWS = cce_pkg::DEF_ROWS,
  parameter int COLS = cce_pkg::DEF_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cce_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cce_pkg::out_item_t out_data_o
);
  import cce_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_MAX   = CW'(COLS - 1);
  localparam logic signed [SRC_W-1:0] ROWS_S = SRC_W'(ROWS);
  localparam logic signed [SRC_W-1:0] COLS_S = SRC_W'(COLS);

  logic [7:0] canvas_mem [CELLS];
  logic [7:0] rd_data_q;

  state_e    state_q, state_d;
  in_item_t  req_q, req_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  prefix_e   prefix_q, prefix_d;
  logic      session_q, session_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic      desc_q, desc_d;
  logic [AW-1:0] delta_q, delta_d;
  logic      p_valid_q, p_valid_d;
  logic [AW-1:0] p_addr_q, p_addr_d;
  logic      p_ok_q, p_ok_d;
  logic [7:0] res_char_q, res_char_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] mem_ra;

  logic          out_free;
  logic          sweep_last;
  logic          src_ok;
  logic signed [SRC_W-1:0] src_row, src_col;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] read_addr;
  logic          read_ok;
  logic          shift_desc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sweep_last = desc_q ? (addr_q == '0) : (addr_q == LAST_ADDR);

  // Source cell of the current destination during a shift.
  assign src_row = signed'(SRC_W'(row_q)) - SRC_W'(req_q.row_shift);
  assign src_col = signed'(SRC_W'(col_q)) - SRC_W'(req_q.col_shift);
  assign src_ok  = (src_row >= 0) && (src_row < ROWS_S) &&
                   (src_col >= 0) && (src_col < COLS_S);

  assign cur_addr  = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
  assign read_addr = AW'(req_q.read_row) * COLS_A + AW'(req_q.read_col);
  assign read_ok   = (int'(req_q.read_row) < ROWS) && (int'(req_q.read_col) < COLS);

  // Content moving toward higher addresses is swept from the top down, so
  // every source cell is read before it is overwritten.
  assign shift_desc = (req_q.row_shift > 0) ||
                      ((req_q.row_shift == 0) && (req_q.col_shift > 0));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (addr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (req_q.req_type)
          REQ_REPLACE, REQ_SHIFT: state_d = ST_SWEEP;
          REQ_READ:               state_d = ST_READ;
          default:                state_d = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        if (sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_READ:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    req_d       = req_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    prefix_d    = prefix_q;
    session_d   = session_q;
    addr_d      = addr_q;
    row_d       = row_q;
    col_d       = col_q;
    desc_d      = desc_q;
    delta_d     = delta_q;
    p_valid_d   = 1'b0;
    p_addr_d    = p_addr_q;
    p_ok_d      = p_ok_q;
    res_char_d  = res_char_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_wa      = p_addr_q;
    mem_wd      = SPACE_CHAR;
    mem_ra      = addr_q;

    // Write-back stage of the sweep pipeline.
    if (p_valid_q) begin
      mem_we = 1'b1;
      if (req_q.req_type == REQ_SHIFT) begin
        mem_wd = p_ok_q ? rd_data_q : SPACE_CHAR;
      end else begin
        mem_wd = (rd_data_q == req_q.old_char) ? req_q.new_char : rd_data_q;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = addr_q;
        mem_wd = SPACE_CHAR;
        addr_d = addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) req_d = in_data_i;
      end
      ST_DECODE: begin
        res_char_d = '0;
        delta_d    = AW'(req_q.row_shift) * COLS_A + AW'(req_q.col_shift);
        desc_d     = shift_desc;
        if (shift_desc) begin
          addr_d = LAST_ADDR;
          row_d  = ROW_MAX;
          col_d  = COL_MAX;
        end else begin
          addr_d = '0;
          row_d  = '0;
          col_d  = '0;
        end
        case (req_q.req_type)
          REQ_KEY: begin
            if (session_q) begin
              if (prefix_q == PFX_ARROW) begin
                prefix_d = PFX_NONE;
                case (req_q.key_code)
                  KEY_UP: begin
                    if (cur_row_q != '0) cur_row_d = cur_row_q - 1'b1;
                  end
                  KEY_DOWN: begin
                    if (cur_row_q != ROW_MAX) cur_row_d = cur_row_q + 1'b1;
                  end
                  KEY_RIGHT: begin
                    if (cur_col_q != COL_MAX) cur_col_d = cur_col_q + 1'b1;
                  end
                  KEY_LEFT: begin
                    if (cur_col_q != '0) cur_col_d = cur_col_q - 1'b1;
                  end
                  default: ;
                endcase
              end else if (prefix_q != PFX_NONE) begin
                prefix_d = PFX_NONE;
              end else if (req_q.key_code == KEY_ARROW_PFX) begin
                prefix_d = PFX_ARROW;
              end else if (req_q.key_code == KEY_NULL_PFX) begin
                prefix_d = PFX_DISCARD;
              end else if (req_q.key_code == KEY_ESC) begin
                session_d = 1'b0;
              end else if (req_q.key_code inside {[PRINT_LO:PRINT_HI]}) begin
                mem_we = 1'b1;
                mem_wa = cur_addr;
                mem_wd = req_q.key_code;
              end
            end
          end
          REQ_READ: begin
            mem_ra = read_addr;
            p_ok_d = read_ok;
          end
          REQ_START: begin
            cur_row_d = '0;
            cur_col_d = '0;
            prefix_d  = PFX_NONE;
            session_d = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SWEEP: begin
        if (req_q.req_type == REQ_SHIFT && src_ok) begin
          mem_ra = addr_q - delta_q;
        end else begin
          mem_ra = addr_q;
        end
        p_valid_d = 1'b1;
        p_addr_d  = addr_q;
        p_ok_d    = src_ok;
        if (desc_q) begin
          addr_d = addr_q - 1'b1;
          if (col_q == '0) begin
            col_d = COL_MAX;
            row_d = row_q - 1'b1;
          end else begin
            col_d = col_q - 1'b1;
          end
        end else begin
          addr_d = addr_q + 1'b1;
          if (col_q == COL_MAX) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        res_char_d = p_ok_q ? rd_data_q : '0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d.read_char      = res_char_q;
          out_data_d.cursor_row_out = 5'(cur_row_q);
          out_data_d.cursor_col_out = 7'(cur_col_q);
          out_data_d.editing        = session_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      prefix_q    <= PFX_NONE;
      session_q   <= 1'b0;
      addr_q      <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      prefix_q    <= prefix_d;
      session_q   <= session_d;
      addr_q      <= addr_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    row_q      <= row_d;
    col_q      <= col_d;
    desc_q     <= desc_d;
    delta_q    <= delta_d;
    p_addr_q   <= p_addr_d;
    p_ok_q     <= p_ok_d;
    res_char_q <= res_char_d;
    out_data_q <= out_data_d;
  end

  // Canvas memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) canvas_mem[mem_wa] <= mem_wd;
    rd_data_q <= canvas_mem[mem_ra];
  end

endmodule
